// ===== hw/rtl/tppu_pkg.sv =====
package tppu_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_W       = PROD_W;
  localparam int SIZE_W      = 13;
  localparam int CLAMP_SHIFT = 48;
  localparam int T_W         = CLAMP_SHIFT + 2;
  localparam int LANES       = 3;
  localparam int LANE_LAT    = DIV_W + 6;
  localparam int ADDR_W      = 5;
  localparam int IDX_W       = ADDR_W - 2;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  localparam logic signed [PROD_W-1:0] ONE_Q    = ONE_L;
  localparam logic signed [PROD_W-1:0] CLAMP_HI = longint'(1) << CLAMP_SHIFT;
  localparam logic signed [PROD_W-1:0] CLAMP_LO = -(longint'(1) << CLAMP_SHIFT);
  localparam logic signed [PROD_W-1:0] SAT_HI   = (longint'(1) << (DATA_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SAT_LO   = -(longint'(1) << (DATA_W - 1));

  localparam logic [DATA_W-1:0] RST_X_SCALE  = DATA_W'((15 * ONE_L) / 16);
  localparam logic [DATA_W-1:0] RST_Y_SCALE  = DATA_W'(ONE_L);
  localparam logic [DATA_W-1:0] RST_Z_SCALE  = DATA_W'((ONE_L * 10000 + 4999) / 9999);
  localparam logic [DATA_W-1:0] RST_Z_OFFSET = DATA_W'(-((ONE_L * 1000 + 4999) / 9999));
  localparam logic [SIZE_W-1:0] RST_WIDTH    = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RST_HEIGHT   = SIZE_W'(240);

  typedef enum logic [IDX_W-1:0] {
    REG_X_SCALE       = 3'd0,
    REG_Y_SCALE       = 3'd1,
    REG_Z_SCALE       = 3'd2,
    REG_Z_OFFSET      = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } tppu_reg_e;

  typedef struct packed {
    logic [DATA_W-1:0] x_scale;
    logic [DATA_W-1:0] y_scale;
    logic [DATA_W-1:0] z_scale;
    logic [DATA_W-1:0] z_offset;
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
  } tppu_cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0]  num;
    logic [DATA_W-1:0] den;
    logic              neg;
  } tppu_div_in_t;

endpackage

// ===== hw/rtl/tppu_cfg.sv =====
module tppu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tppu_pkg::ADDR_W-1:0]    paddr,
  input  logic [tppu_pkg::DATA_W-1:0]    pwdata,
  output logic [tppu_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output tppu_pkg::tppu_cfg_t            cfg_o
);

  tppu_pkg::tppu_cfg_t cfg_q;
  tppu_pkg::tppu_reg_e idx;
  logic                wr;

  assign idx    = tppu_pkg::tppu_reg_e'(paddr[tppu_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale       <= tppu_pkg::RST_X_SCALE;
      cfg_q.y_scale       <= tppu_pkg::RST_Y_SCALE;
      cfg_q.z_scale       <= tppu_pkg::RST_Z_SCALE;
      cfg_q.z_offset      <= tppu_pkg::RST_Z_OFFSET;
      cfg_q.screen_width  <= tppu_pkg::RST_WIDTH;
      cfg_q.screen_height <= tppu_pkg::RST_HEIGHT;
    end else if (wr) begin
      case (idx)
        tppu_pkg::REG_X_SCALE:       cfg_q.x_scale       <= pwdata;
        tppu_pkg::REG_Y_SCALE:       cfg_q.y_scale       <= pwdata;
        tppu_pkg::REG_Z_SCALE:       cfg_q.z_scale       <= pwdata;
        tppu_pkg::REG_Z_OFFSET:      cfg_q.z_offset      <= pwdata;
        tppu_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[tppu_pkg::SIZE_W-1:0];
        tppu_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[tppu_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tppu_pkg::REG_X_SCALE:       prdata = cfg_q.x_scale;
      tppu_pkg::REG_Y_SCALE:       prdata = cfg_q.y_scale;
      tppu_pkg::REG_Z_SCALE:       prdata = cfg_q.z_scale;
      tppu_pkg::REG_Z_OFFSET:      prdata = cfg_q.z_offset;
      tppu_pkg::REG_SCREEN_WIDTH:
        prdata = {{(tppu_pkg::DATA_W-tppu_pkg::SIZE_W){1'b0}}, cfg_q.screen_width};
      tppu_pkg::REG_SCREEN_HEIGHT:
        prdata = {{(tppu_pkg::DATA_W-tppu_pkg::SIZE_W){1'b0}}, cfg_q.screen_height};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tppu_div.sv =====
module tppu_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  tppu_pkg::tppu_div_in_t              in_i,
  output logic signed [tppu_pkg::PROD_W-1:0]  q_o
);

  localparam int DW = tppu_pkg::DATA_W;
  localparam int NW = tppu_pkg::DIV_W;

  // one quotient bit per stage, magnitude restoring division
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];
  logic          neg_q [NW];

  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] nq_d  [NW];

  logic [DW-1:0] src_rem [NW];
  logic [NW-1:0] src_nq  [NW];
  logic [DW-1:0] src_den [NW];
  logic          src_neg [NW];

  logic signed [tppu_pkg::PROD_W-1:0] q_d, q_q;

  always_comb begin
    src_rem[0] = '0;
    src_nq[0]  = in_i.num;
    src_den[0] = in_i.den;
    src_neg[0] = in_i.neg;
    for (int k = 1; k < NW; k++) begin
      src_rem[k] = rem_q[k-1];
      src_nq[k]  = nq_q[k-1];
      src_den[k] = den_q[k-1];
      src_neg[k] = neg_q[k-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int k = 0; k < NW; k++) begin
      trial = {src_rem[k], src_nq[k][NW-1]};
      diff  = trial - {1'b0, src_den[k]};
      if (!diff[DW]) begin
        rem_d[k] = diff[DW-1:0];
        nq_d[k]  = {src_nq[k][NW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[DW-1:0];
        nq_d[k]  = {src_nq[k][NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_q[NW-1]) begin
      q_d = -signed'(nq_q[NW-1]);
    end else begin
      q_d = signed'(nq_q[NW-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NW; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= src_den[k];
        neg_q[k] <= src_neg[k];
      end
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== hw/rtl/tppu_lane.sv =====
module tppu_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  x_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  y_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  z_i,
  input  tppu_pkg::tppu_cfg_t                 cfg_i,
  output logic signed [tppu_pkg::DATA_W-1:0]  sx_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  sy_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  depth_o
);

  localparam int DW = tppu_pkg::DATA_W;
  localparam int PW = tppu_pkg::PROD_W;
  localparam int TW = tppu_pkg::T_W;
  localparam int SW = tppu_pkg::SIZE_W;

  // zero w: floor shift, carried through the divider as a divide by one
  function automatic tppu_pkg::tppu_div_in_t div_prep(input logic signed [PW-1:0] p,
                                                      input logic signed [DW-1:0] w);
    tppu_pkg::tppu_div_in_t r;
    logic signed [PW-1:0]   v;
    logic signed [PW-1:0]   nv;
    logic signed [DW-1:0]   nw;
    nw = -w;
    if (w == '0) begin
      v     = p >>> tppu_pkg::FRAC_BITS;
      r.den = {{(DW-1){1'b0}}, 1'b1};
    end else begin
      v     = p;
      r.den = w[DW-1] ? nw : w;
    end
    nv    = -v;
    r.num = v[PW-1] ? nv : v;
    r.neg = v[PW-1] ^ w[DW-1];
    return r;
  endfunction

  function automatic logic signed [TW-1:0] view_bias(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] c;
    logic signed [PW-1:0] s;
    if (p > tppu_pkg::CLAMP_HI) begin
      c = tppu_pkg::CLAMP_HI;
    end else if (p < tppu_pkg::CLAMP_LO) begin
      c = tppu_pkg::CLAMP_LO;
    end else begin
      c = p;
    end
    s = c + tppu_pkg::ONE_Q;
    return s[TW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    if (v > tppu_pkg::SAT_HI) begin
      c = tppu_pkg::SAT_HI;
    end else if (v < tppu_pkg::SAT_LO) begin
      c = tppu_pkg::SAT_LO;
    end else begin
      c = v;
    end
    return c[DW-1:0];
  endfunction

  logic signed [DW-1:0] xs, ys, zs, zo;
  logic signed [PW-1:0] zoff_ext;
  logic signed [SW:0]   wid_s, hgt_s;

  logic signed [PW-1:0] px_a_q, py_a_q, pz_a_q;
  logic signed [DW-1:0] z_a_q;
  logic signed [PW-1:0] px_b_q, py_b_q, pz_b_q;
  logic signed [DW-1:0] z_b_q;
  tppu_pkg::tppu_div_in_t dx_c_q, dy_c_q, dz_c_q;
  logic signed [PW-1:0] qx, qy, qz;
  logic signed [TW-1:0] tx_f_q, ty_f_q;
  logic signed [DW-1:0] dep_f_q, dep_g_q;
  logic signed [PW-1:0] mx_g_q, my_g_q;

  assign xs       = signed'(cfg_i.x_scale);
  assign ys       = signed'(cfg_i.y_scale);
  assign zs       = signed'(cfg_i.z_scale);
  assign zo       = signed'(cfg_i.z_offset);
  assign zoff_ext = zo;
  assign wid_s    = signed'({1'b0, cfg_i.screen_width});
  assign hgt_s    = signed'({1'b0, cfg_i.screen_height});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_a_q  <= x_i * xs;
      py_a_q  <= y_i * ys;
      pz_a_q  <= z_i * zs;
      z_a_q   <= z_i;

      px_b_q  <= px_a_q;
      py_b_q  <= py_a_q;
      pz_b_q  <= pz_a_q + (zoff_ext <<< tppu_pkg::FRAC_BITS);
      z_b_q   <= z_a_q;

      dx_c_q  <= div_prep(px_b_q, z_b_q);
      dy_c_q  <= div_prep(py_b_q, z_b_q);
      dz_c_q  <= div_prep(pz_b_q, z_b_q);

      tx_f_q  <= view_bias(qx);
      ty_f_q  <= view_bias(qy);
      dep_f_q <= sat32(qz);

      mx_g_q  <= tx_f_q * wid_s;
      my_g_q  <= ty_f_q * hgt_s;
      dep_g_q <= dep_f_q;
    end
  end

  tppu_div u_div_x (.clk_i(clk_i), .en_i(en_i), .in_i(dx_c_q), .q_o(qx));
  tppu_div u_div_y (.clk_i(clk_i), .en_i(en_i), .in_i(dy_c_q), .q_o(qy));
  tppu_div u_div_z (.clk_i(clk_i), .en_i(en_i), .in_i(dz_c_q), .q_o(qz));

  assign sx_o    = sat32(mx_g_q >>> 1);
  assign sy_o    = sat32(my_g_q >>> 1);
  assign depth_o = dep_g_q;

endmodule

// ===== hw/rtl/triangle_perspective_projection_unit.sv =====
// Projects one triangle per transfer to screen x, y and depth in signed Q16.16. Three vertex
// lanes run side by side, each with three 64-stage bit-per-cycle dividers, so a new triangle
// is accepted every cycle unless the output side stalls with a result waiting; the divider
// depth sets most of the pipeline depth. Write the APB registers only while no triangle is
// in flight.
module triangle_perspective_projection_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tppu_pkg::ADDR_W-1:0]         paddr,
  input  logic [tppu_pkg::DATA_W-1:0]         pwdata,
  output logic [tppu_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v0_x_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v0_y_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v0_z_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v1_x_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v1_y_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v1_z_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v2_x_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v2_y_i,
  input  logic signed [tppu_pkg::DATA_W-1:0]  v2_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tppu_pkg::DATA_W-1:0]  s0_x_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s0_y_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s0_depth_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s1_x_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s1_y_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s1_depth_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s2_x_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s2_y_o,
  output logic signed [tppu_pkg::DATA_W-1:0]  s2_depth_o
);

  localparam int DW  = tppu_pkg::DATA_W;
  localparam int LN  = tppu_pkg::LANES;
  localparam int LAT = tppu_pkg::LANE_LAT;

  tppu_pkg::tppu_cfg_t cfg;

  logic signed [DW-1:0] vx [LN];
  logic signed [DW-1:0] vy [LN];
  logic signed [DW-1:0] vz [LN];
  logic signed [DW-1:0] lsx [LN];
  logic signed [DW-1:0] lsy [LN];
  logic signed [DW-1:0] ldep [LN];
  logic signed [DW-1:0] sx_q [LN];
  logic signed [DW-1:0] sy_q [LN];
  logic signed [DW-1:0] dep_q [LN];

  logic [LAT-1:0] vld_q;
  logic           out_valid_q;
  logic           out_free;
  logic           advance;

  tppu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign vx[0] = v0_x_i;
  assign vy[0] = v0_y_i;
  assign vz[0] = v0_z_i;
  assign vx[1] = v1_x_i;
  assign vy[1] = v1_y_i;
  assign vz[1] = v1_z_i;
  assign vx[2] = v2_x_i;
  assign vy[2] = v2_y_i;
  assign vz[2] = v2_z_i;

  // pipeline moves when the output slot frees up or the last stage holds a bubble
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = out_free || !vld_q[LAT-1];
  assign in_ready_o = advance;

  for (genvar l = 0; l < LN; l++) begin : g_lane
    tppu_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (advance),
      .x_i     (vx[l]),
      .y_i     (vy[l]),
      .z_i     (vz[l]),
      .cfg_i   (cfg),
      .sx_o    (lsx[l]),
      .sy_o    (lsy[l]),
      .depth_o (ldep[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (out_free) begin
        out_valid_q <= vld_q[LAT-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && vld_q[LAT-1]) begin
      for (int l = 0; l < LN; l++) begin
        sx_q[l]  <= lsx[l];
        sy_q[l]  <= lsy[l];
        dep_q[l] <= ldep[l];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign s0_x_o      = sx_q[0];
  assign s0_y_o      = sy_q[0];
  assign s0_depth_o  = dep_q[0];
  assign s1_x_o      = sx_q[1];
  assign s1_y_o      = sy_q[1];
  assign s1_depth_o  = dep_q[1];
  assign s2_x_o      = sx_q[2];
  assign s2_y_o      = sy_q[2];
  assign s2_depth_o  = dep_q[2];

endmodule

// ===== hw/rtl/tppu_checker.sv =====
module tppu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [tppu_pkg::ADDR_W-1:0]         paddr,
  input logic [tppu_pkg::DATA_W-1:0]         pwdata,
  input logic [tppu_pkg::DATA_W-1:0]         prdata,
  input logic                                pready,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  v0_x_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v0_y_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v0_z_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v1_x_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v1_y_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v1_z_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v2_x_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v2_y_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  v2_z_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [tppu_pkg::DATA_W-1:0]  s0_x_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s0_y_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s0_depth_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s1_x_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s1_y_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s1_depth_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s2_x_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s2_y_o,
  input logic signed [tppu_pkg::DATA_W-1:0]  s2_depth_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(s0_x_o) && $stable(s1_y_o)
      && $stable(s2_depth_o))
    else $error("result changed while stalled");

  // a free output slot never blocks the input side
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input blocked with free output slot");

  // a written x_scale register reads back
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[tppu_pkg::ADDR_W-1:2] == tppu_pkg::REG_X_SCALE && $past(rst_ni)
      && $past(psel && penable && pwrite && pready
               && paddr[tppu_pkg::ADDR_W-1:2] == tppu_pkg::REG_X_SCALE)
    |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind triangle_perspective_projection_unit tppu_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
  import tppu_pkg::*;

  localparam int NUM_FIELDS = 3 * LANES;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = LANE_LAT + 20;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 50;
  localparam int ONE_I = int'(ONE_L);
  localparam int W_MIN = int'(32'h8000_0000);
  localparam int W_MAX = int'(32'h7fff_ffff);
  localparam longint P_LIMIT = longint'(1) << CLAMP_SHIFT;
  localparam logic [IDX_W-1:0] UNUSED_REG_LO = IDX_W'(REG_SCREEN_HEIGHT + 1);
  localparam logic [IDX_W-1:0] UNUSED_REG_HI = IDX_W'(REG_SCREEN_HEIGHT + 2);

  typedef logic [NUM_FIELDS-1:0][DATA_W-1:0] tri_vec_t;

  class screen_scoreboard;
    longint x_scale, y_scale, z_scale, z_offset, width, height;
    tri_vec_t pending_screens[$];
    int mismatches;

    function new();
      x_scale = longint'(signed'(RST_X_SCALE));
      y_scale = longint'(signed'(RST_Y_SCALE));
      z_scale = longint'(signed'(RST_Z_SCALE));
      z_offset = longint'(signed'(RST_Z_OFFSET));
      width = longint'(RST_WIDTH);
      height = longint'(RST_HEIGHT);
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_X_SCALE: x_scale = longint'(signed'(val));
        REG_Y_SCALE: y_scale = longint'(signed'(val));
        REG_Z_SCALE: z_scale = longint'(signed'(val));
        REG_Z_OFFSET: z_offset = longint'(signed'(val));
        REG_SCREEN_WIDTH: width = longint'(val[SIZE_W-1:0]);
        REG_SCREEN_HEIGHT: height = longint'(val[SIZE_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint bound(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // divide by w, or drop the extra fraction bits when w is zero
    function longint perspective_div(longint p, longint w);
      if (w != 0) return p / w;
      return p >>> FRAC_BITS;
    endfunction

    function longint viewport(longint p, longint size);
      return ((bound(p, -P_LIMIT, P_LIMIT) + ONE_L) * size) >>> 1;
    endfunction

    function logic [DATA_W-1:0] saturate(longint v);
      return DATA_W'(bound(v, longint'(W_MIN), longint'(W_MAX)));
    endfunction

    function tri_vec_t project(tri_vec_t t);
      tri_vec_t s;
      longint x, y, z;
      for (int v = 0; v < LANES; v++) begin
        x = longint'(signed'(t[3*v]));
        y = longint'(signed'(t[3*v+1]));
        z = longint'(signed'(t[3*v+2]));
        s[3*v] = saturate(viewport(perspective_div(x * x_scale, z), width));
        s[3*v+1] = saturate(viewport(perspective_div(y * y_scale, z), height));
        s[3*v+2] = saturate(perspective_div(z * z_scale + z_offset * ONE_L, z));
      end
      return s;
    endfunction

    function void note_triangle(tri_vec_t t);
      pending_screens.push_back(project(t));
    endfunction

    function void check_screen(tri_vec_t s);
      tri_vec_t want;
      if (pending_screens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result transfer, got %h", $time, s);
        return;
      end
      want = pending_screens.pop_front();
      for (int f = 0; f < NUM_FIELDS; f++) begin
        if (s[f] !== want[f]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: s%0d_%s mismatch: expected %0d, actual %0d", $time, f / 3,
                     (f % 3 == 2) ? "depth" : ((f % 3 == 1) ? "y" : "x"),
                     $signed(want[f]), $signed(s[f]));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  tri_vec_t tri_in;
  logic out_valid;
  logic out_ready;
  wire [NUM_FIELDS-1:0][DATA_W-1:0] scr_out;

  screen_scoreboard board;
  bit hold_req;
  bit rx_quiet;
  longint cycles = 0;
  tri_vec_t corner_tris[$];

  triangle_perspective_projection_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .v0_x_i     (tri_in[0]),
    .v0_y_i     (tri_in[1]),
    .v0_z_i     (tri_in[2]),
    .v1_x_i     (tri_in[3]),
    .v1_y_i     (tri_in[4]),
    .v1_z_i     (tri_in[5]),
    .v2_x_i     (tri_in[6]),
    .v2_y_i     (tri_in[7]),
    .v2_z_i     (tri_in[8]),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .s0_x_o     (scr_out[0]),
    .s0_y_o     (scr_out[1]),
    .s0_depth_o (scr_out[2]),
    .s1_x_o     (scr_out[3]),
    .s1_y_o     (scr_out[4]),
    .s1_depth_o (scr_out[5]),
    .s2_x_o     (scr_out[6]),
    .s2_y_o     (scr_out[7]),
    .s2_depth_o (scr_out[8])
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_screen(scr_out);
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return $urandom_range(3, 1);
    if (pick < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(99) < 45) return 0;
    return idle_len();
  endfunction

  function automatic int corner_word();
    int pick;
    pick = $urandom_range(7);
    case (pick)
      0: return W_MIN;
      1: return W_MAX;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return ONE_I;
      6: return -ONE_I;
      default: return int'($urandom());
    endcase
  endfunction

  function automatic tri_vec_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x2, int y2, int z2);
    tri_vec_t t;
    t[0] = x0; t[1] = y0; t[2] = z0;
    t[3] = x1; t[4] = y1; t[5] = z1;
    t[6] = x2; t[7] = y2; t[8] = z2;
    return t;
  endfunction

  function automatic tri_vec_t random_triangle();
    tri_vec_t t;
    int kind, zmag, x, y, z;
    for (int v = 0; v < LANES; v++) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        zmag = $urandom_range(64 * ONE_I, ONE_I / 8);
        z = ($urandom_range(4) == 0) ? -zmag : zmag;
        x = int'($urandom_range(4 * zmag)) - 2 * zmag;
        y = int'($urandom_range(4 * zmag)) - 2 * zmag;
      end else if (kind < 70) begin
        z = 0;
        x = ($urandom_range(1)) ? int'($urandom()) : int'($urandom_range(8 * ONE_I)) - 4 * ONE_I;
        y = ($urandom_range(1)) ? int'($urandom()) : int'($urandom_range(8 * ONE_I)) - 4 * ONE_I;
      end else if (kind < 85) begin
        x = int'($urandom());
        y = int'($urandom());
        z = int'($urandom());
      end else begin
        x = corner_word();
        y = corner_word();
        z = corner_word();
      end
      t[3*v] = x;
      t[3*v+1] = y;
      t[3*v+2] = z;
    end
    return t;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_view(logic [DATA_W-1:0] xs, logic [DATA_W-1:0] ys,
                              logic [DATA_W-1:0] zs, logic [DATA_W-1:0] zo,
                              logic [DATA_W-1:0] w, logic [DATA_W-1:0] h);
    write_reg(REG_X_SCALE, xs);
    write_reg(REG_Y_SCALE, ys);
    write_reg(REG_Z_SCALE, zs);
    write_reg(REG_Z_OFFSET, zo);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  task automatic send_triangle(tri_vec_t t);
    @(negedge clk);
    in_valid <= 1'b1;
    tri_in <= t;
    do @(posedge clk); while (!in_ready);
    board.note_triangle(t);
  endtask

  task automatic idle_sender(int n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_corners();
    foreach (corner_tris[i]) begin
      send_triangle(corner_tris[i]);
      idle_sender(sender_gap());
    end
  endtask

  task automatic send_random(int count, bit tight);
    for (int i = 0; i < count; i++) begin
      send_triangle(random_triangle());
      if (!tight) idle_sender(sender_gap());
    end
  endtask

  // wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_screens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int rx_stall;
    rx_stall = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else if (rx_quiet || $urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_stall = idle_len() - 1;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    tri_in = '0;
    hold_req = 1'b0;
    rx_quiet = 1'b0;
    board = new();

    corner_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    corner_tris.push_back(make_tri(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, 0));
    // w of zero: undivided, floor rounding on negatives
    corner_tris.push_back(make_tri(W_MAX, W_MIN, 0, -1, 1, 0, -ONE_I, ONE_I / 2, 0));
    corner_tris.push_back(make_tri(ONE_I, -ONE_I, ONE_I, ONE_I / 2, -ONE_I / 2, 2 * ONE_I,
                                   -3, 7, ONE_I));
    // tiny w blows up and saturates
    corner_tris.push_back(make_tri(W_MAX, W_MAX, 1, W_MIN, W_MIN, 1, W_MAX, W_MIN, -1));
    // quotient truncation with mixed signs
    corner_tris.push_back(make_tri(-5, 5, 3, 5, -5, -3, -ONE_I, ONE_I, -ONE_I));
    corner_tris.push_back(make_tri(0, 0, W_MAX, 0, 0, W_MIN, 1, -1, ONE_I));
    corner_tris.push_back(make_tri(-ONE_I, -ONE_I, ONE_I, ONE_I, ONE_I, ONE_I, 0, 0, ONE_I));
    corner_tris.push_back(make_tri(3 * ONE_I, -3 * ONE_I, ONE_I, ONE_I, ONE_I, -ONE_I,
                                   -7 * ONE_I, 9 * ONE_I, 3 * ONE_I));
    corner_tris.push_back(make_tri(int'(32'h5555_5555), int'(32'h5555_5555), int'(32'h5555_5555),
                                   int'(32'haaaa_aaaa), int'(32'haaaa_aaaa), int'(32'haaaa_aaaa),
                                   int'(32'h5555_5555), int'(32'haaaa_aaaa), int'(32'h0000_ffff)));
    corner_tris.push_back(make_tri(W_MAX, W_MAX, ONE_I, W_MIN, W_MIN, -ONE_I,
                                   ONE_I, ONE_I, W_MAX));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_corners();
    send_random(60, 1'b0);
    settle();

    program_view(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000,
                 32'hffff_e000, 32'hffff_ffff);
    send_corners();
    send_random(50, 1'b0);
    settle();

    program_view(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'd4096, 32'd1);
    send_random(50, 1'b0);
    settle();

    // writes past the last register must not disturb anything
    write_reg(UNUSED_REG_LO, $urandom());
    write_reg(UNUSED_REG_HI, $urandom());
    program_view($urandom(), $urandom(), $urandom(), $urandom(),
                 ($urandom() & ~32'h1fff) | $urandom_range(4096, 1),
                 ($urandom() & ~32'h1fff) | $urandom_range(4096, 1));
    hold_req = 1'b1;
    send_random(150, 1'b1);
    settle();

    program_view($urandom_range(2 * ONE_I, ONE_I / 4), $urandom_range(2 * ONE_I, ONE_I / 4),
                 $urandom_range(ONE_I + ONE_I / 8, ONE_I), -int'($urandom_range(ONE_I / 2)),
                 $urandom_range(4096, 1), $urandom_range(4096, 1));
    rx_quiet = 1'b1;
    send_random(60, 1'b1);
    rx_quiet = 1'b0;
    send_random(60, 1'b0);
    settle();

    if (board.mismatches == 0 && board.pending_screens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
